// ----- rtl/brap_pkg.sv -----
// Shared constants, state codes and unit interface types for the button auto-repeat block.
package brap_pkg;

  localparam int NUM_BUTTONS = 9;
  localparam int MASK_W      = 9;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CODE_W      = 4;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_W      = $clog2(TIME_W);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] RESET_DELAY    = 16'd500;
  localparam logic [CFG_W-1:0] RESET_INTERVAL = 16'd100;
  localparam logic [CFG_W-1:0] RESET_WINDOW   = 16'd20;

  localparam logic [CODE_W-1:0] CODE_NONE = '0;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_MOD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Request to the shared remainder unit
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } mod_req_t;

  // Response from the shared remainder unit
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ----- rtl/brap_mod.sv -----
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor, zero divisor passes through.
module brap_mod
  import brap_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [TIME_W-1:0] dvd;
  logic [CFG_W-1:0]  rem;
  logic              zero_div;

  logic [CFG_W:0]    trial;
  logic              fits;
  logic              last_step;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, dvd[TIME_W-1]};
  assign fits  = (trial >= {1'b0, req.divisor});

  assign last_step = zero_div || (step == STEP_W'(TIME_W - 1));

  // Control: start, count steps, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        step <= '0;
      end else if (busy) begin
        if (last_step) begin
          busy <= 1'b0;
        end
        done <= last_step;
        step <= step + STEP_W'(1);
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd      <= req.dividend;
      rem      <= '0;
      zero_div <= (req.divisor == '0);
    end else if (busy && !zero_div) begin
      dvd <= {dvd[TIME_W-2:0], 1'b0};
      if (fits) begin
        rem <= CFG_W'(trial - {1'b0, req.divisor});
      end else begin
        rem <= trial[CFG_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = zero_div ? dvd : {{(TIME_W - CFG_W){1'b0}}, rem};

endmodule

// ----- rtl/button_auto_repeat_priority.sv -----
// Top level: polled nine-button auto-repeat with priority scan and event output register.
//
// One poll is taken when the block is idle and yields exactly one event code. With the pad
// absent a poll goes straight to the output. Otherwise buttons are visited in priority
// order, one at a time: a released button or a first press is settled in the scan state,
// a held button not yet repeating in the scan and check states, and a repeating button
// also in the bit-serial remainder unit, which resolves one bit of the 32-bit phase per
// cycle (and passes the phase through when the interval is zero). The event code is then
// loaded into the output register. The next poll is taken while an event still waits at the
// output; configuration writes are taken at any time and must only be made while idle.
module button_auto_repeat_priority
  import brap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MASK_W-1:0]    pressed_mask,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic                 pad_present,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_W-1:0]    event_code,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t              state;
  logic [IDX_W-1:0]    idx;
  logic [MASK_W-1:0]   mask_q;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   held_q;
  logic [CODE_W-1:0]   code_q;

  logic [CFG_W-1:0]    repeat_delay_ms;
  logic [CFG_W-1:0]    repeat_interval_ms;
  logic [CFG_W-1:0]    repeat_window_ms;

  logic [TIME_W-1:0]   press_stamp   [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] repeat_active;

  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  logic                in_xfer;
  logic                down;
  logic                last_btn;
  logic [TIME_W:0]     over;
  logic                reached;
  logic [CODE_W-1:0]   btn_code;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  assign down     = mask_q[idx];
  assign last_btn = (idx == IDX_W'(NUM_BUTTONS - 1));
  assign btn_code = CODE_W'(idx) + CODE_W'(1);

  // Held time minus delay; the borrow says whether the delay is reached
  assign over    = {1'b0, held_q} - {{(TIME_W + 1 - CFG_W){1'b0}}, repeat_delay_ms};
  assign reached = !over[TIME_W];

  // Hand the phase to the remainder unit
  assign mod_req.start    = (state == S_CHECK) && repeat_active[idx];
  assign mod_req.dividend = over[TIME_W-1:0];
  assign mod_req.divisor  = repeat_interval_ms;

  brap_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay_ms    <= RESET_DELAY;
      repeat_interval_ms <= RESET_INTERVAL;
      repeat_window_ms   <= RESET_WINDOW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY:    repeat_delay_ms    <= cfg_data;
        REG_INTERVAL: repeat_interval_ms <= cfg_data;
        REG_WINDOW:   repeat_window_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the poll on transfer and the held time while scanning
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mask_q <= pressed_mask;
      now_q  <= now_ms;
    end
    if (state == S_SCAN) begin
      held_q <= now_q - press_stamp[idx];
    end
  end

  // Sequencer: scan buttons in priority order, update their state, hold the event code
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      code_q        <= CODE_NONE;
      repeat_active <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_stamp[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            idx    <= '0;
            code_q <= CODE_NONE;
            state  <= pad_present ? S_SCAN : S_OUT;
          end
        end
        S_SCAN: begin
          priority if (!down) begin
            press_stamp[idx]   <= '0;
            repeat_active[idx] <= 1'b0;
            if (last_btn) begin
              state <= S_OUT;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end else if (press_stamp[idx] == '0) begin
            press_stamp[idx] <= now_q;
            code_q           <= btn_code;
            state            <= S_OUT;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (repeat_active[idx]) begin
            state <= S_MOD;
          end else if (reached) begin
            repeat_active[idx] <= 1'b1;
            code_q             <= btn_code;
            state              <= S_OUT;
          end else if (last_btn) begin
            state <= S_OUT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SCAN;
          end
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            priority if (mod_rsp.rem < {{(TIME_W - CFG_W){1'b0}}, repeat_window_ms}) begin
              code_q <= btn_code;
              state  <= S_OUT;
            end else if (last_btn) begin
              state <= S_OUT;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_SCAN;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when the slot is free, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      event_code <= code_q;
    end
  end

  // A finished remainder only arrives while the sequencer waits for it
  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> (state == S_MOD))
    else $error("remainder finished outside its wait state");

  // An absent pad goes straight to the output with no event
  a_absent_no_event: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !pad_present) |=> ((state == S_OUT) && (code_q == CODE_NONE)))
    else $error("absent pad did not yield an empty event");

  // A button with no stored press can never be repeating
  a_stamp_repeat: assert property (@(posedge clk) disable iff (rst)
    (press_stamp[idx] == '0) |-> !repeat_active[idx])
    else $error("repeat flag set on a button with no press stamp");

  // Event codes stay within the button range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_code <= CODE_W'(NUM_BUTTONS)))
    else $error("event code out of range");

endmodule

// ----- bench/button_auto_repeat_priority_tb.sv -----
// Self-checking bench for the nine-button auto-repeat block with its own event predictor.
module button_auto_repeat_priority_tb;
  import brap_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 400;
  localparam int DIRECTED_ROWS = 18;
  localparam int PHASES = 10;
  localparam int POLLS_PER_PHASE = 148;

  // One directed poll: payload plus an optional hand-typed event code
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] now;
    logic              present;
    logic              typed;
    logic [CODE_W-1:0] code;
  } poll_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MASK_W-1:0]    pressed_mask = '0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 pad_present = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CODE_W-1:0]    event_code;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Travels with the payload: use the typed code instead of the predicted one
  logic                 row_typed = 1'b0;
  logic [CODE_W-1:0]    row_code = '0;

  // Predictor state and its copy of the registers
  logic [TIME_W-1:0]    held_since [NUM_BUTTONS];
  logic                 repeating [NUM_BUTTONS];
  logic [CFG_W-1:0]     rpt_delay;
  logic [CFG_W-1:0]     rpt_period;
  logic [CFG_W-1:0]     rpt_window;

  logic [CODE_W-1:0]    pending_codes [$];
  logic [CODE_W-1:0]    predicted;
  logic [CODE_W-1:0]    wanted;
  int                   mismatches = 0;
  int                   quiet_cycles = 0;
  bit                   idle_on = 1'b1;
  poll_row_t            directed_polls [DIRECTED_ROWS];

  button_auto_repeat_priority u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pressed_mask (pressed_mask),
    .now_ms       (now_ms),
    .pad_present  (pad_present),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scan the buttons in priority order and stop at the first one that fires
  function automatic logic [CODE_W-1:0] next_event_code(input logic [MASK_W-1:0] mask,
                                                        input logic [TIME_W-1:0] now,
                                                        input logic present);
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] phase;
    logic [CODE_W-1:0] code;
    logic              fire;
    int                b;
    code = CODE_NONE;
    if (present) begin
      for (b = 0; b < NUM_BUTTONS && code == CODE_NONE; b++) begin
        fire = 1'b0;
        if (!mask[b]) begin
          held_since[b] = '0;
          repeating[b] = 1'b0;
        end else if (held_since[b] == '0) begin
          // a press stamped at time zero stays unstamped
          held_since[b] = now;
          fire = 1'b1;
        end else begin
          held = now - held_since[b];
          if (!repeating[b] && held >= TIME_W'(rpt_delay)) begin
            repeating[b] = 1'b1;
            fire = 1'b1;
          end else if (repeating[b]) begin
            phase = held - TIME_W'(rpt_delay);
            // a zero period leaves the phase as it is
            if (rpt_period != '0) phase = phase % TIME_W'(rpt_period);
            fire = (phase < TIME_W'(rpt_window));
          end
        end
        if (fire) code = CODE_W'(b + 1);
      end
    end
    return code;
  endfunction

  task automatic note_mismatch(input string what, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("event_code error (%s): expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  // Track register writes, predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (rst) begin
      rpt_delay = RESET_DELAY;
      rpt_period = RESET_INTERVAL;
      rpt_window = RESET_WINDOW;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        held_since[b] = '0;
        repeating[b] = 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY:    rpt_delay = cfg_data;
          REG_INTERVAL: rpt_period = cfg_data;
          REG_WINDOW:   rpt_window = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predicted = next_event_code(pressed_mask, now_ms, pad_present);
        pending_codes.push_back(row_typed ? row_code : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_codes.size() == 0) begin
          note_mismatch("no poll outstanding", CODE_NONE, event_code);
        end else begin
          wanted = pending_codes.pop_front();
          if (event_code !== wanted) note_mismatch("poll result", wanted, event_code);
        end
      end
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Accept results, with a random stall before each one while idle_on is set
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one poll, after a random gap while idle_on is set, and hold it until the transfer
  task automatic send_poll(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now,
                           input logic present, input logic typed,
                           input logic [CODE_W-1:0] code);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed_mask <= mask;
    now_ms <= now;
    pad_present <= present;
    row_typed <= typed;
    row_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and hold until every outstanding result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0]  set_delay;
    logic [CFG_W-1:0]  set_period;
    logic [CFG_W-1:0]  set_window;
    logic [MASK_W-1:0] held_mask;
    logic [TIME_W-1:0] clock_ms;
    int                step_max;
    int                roll;

    // Directed polls under the reset settings (delay 500, period 100, window 20)
    directed_polls[0]  = '{9'h000, 32'd0,          1'b1, 1'b1, 4'd0};
    directed_polls[1]  = '{9'h1FF, 32'd1000,       1'b0, 1'b1, CODE_NONE};
    directed_polls[2]  = '{9'h1FF, 32'd1000,       1'b1, 1'b1, 4'd1};
    directed_polls[3]  = '{9'h1FF, 32'd1001,       1'b1, 1'b0, 4'd0};
    directed_polls[4]  = '{9'h1FE, 32'd1002,       1'b1, 1'b0, 4'd0};
    directed_polls[5]  = '{9'h100, 32'd1003,       1'b1, 1'b0, 4'd0};
    directed_polls[6]  = '{9'h100, 32'd1503,       1'b1, 1'b0, 4'd0};
    directed_polls[7]  = '{9'h100, 32'd1603,       1'b1, 1'b0, 4'd0};
    directed_polls[8]  = '{9'h100, 32'd1623,       1'b1, 1'b0, 4'd0};
    directed_polls[9]  = '{9'h100, 32'd1622,       1'b1, 1'b0, 4'd0};
    directed_polls[10] = '{9'h001, 32'd0,          1'b1, 1'b1, 4'd1};
    directed_polls[11] = '{9'h001, 32'd5,          1'b1, 1'b1, 4'd1};
    directed_polls[12] = '{9'h000, 32'd10,         1'b1, 1'b1, CODE_NONE};
    directed_polls[13] = '{9'h002, 32'hFFFF_FF00,  1'b1, 1'b0, 4'd0};
    directed_polls[14] = '{9'h002, 32'h0000_00F4,  1'b1, 1'b0, 4'd0};
    directed_polls[15] = '{9'h1FF, 32'hFFFF_FFFF,  1'b1, 1'b0, 4'd0};
    directed_polls[16] = '{9'h1FF, 32'hFFFF_FFFF,  1'b0, 1'b1, CODE_NONE};
    directed_polls[17] = '{9'h080, 32'd7,          1'b1, 1'b0, 4'd0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_poll(directed_polls[r].mask, directed_polls[r].now, directed_polls[r].present,
                directed_polls[r].typed, directed_polls[r].code);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Pick the settings: fixed corner and reset settings first, then random ones
      case (ph)
        0: begin set_delay = 16'd0;      set_period = 16'd1;      set_window = 16'd0;      end
        1: begin set_delay = 16'd0;      set_period = 16'd1;      set_window = 16'd1;      end
        2: begin set_delay = 16'hFFFF;   set_period = 16'hFFFF;   set_window = 16'hFFFF;   end
        3: begin set_delay = 16'd5;      set_period = 16'd0;      set_window = 16'd40;     end
        4: begin set_delay = RESET_DELAY; set_period = RESET_INTERVAL; set_window = RESET_WINDOW; end
        9: begin
          set_delay = CFG_W'($urandom);
          set_period = CFG_W'($urandom);
          set_window = CFG_W'($urandom);
        end
        default: begin
          set_delay = CFG_W'($urandom_range(0, 40));
          set_period = CFG_W'($urandom_range(1, 30));
          set_window = CFG_W'($urandom_range(0, set_period + 2));
        end
      endcase
      idle_on = (ph % 3 != 1);

      // Write all three registers back to back while the block is idle
      write_reg(REG_DELAY, set_delay);
      write_reg(REG_INTERVAL, set_period);
      write_reg(REG_WINDOW, set_window);
      cfg_valid <= 1'b0;

      case (ph % 4)
        0: clock_ms = 32'hFFFF_FE00;
        1: clock_ms = '0;
        2: clock_ms = $urandom;
        default: clock_ms = 32'd1000;
      endcase
      step_max = set_delay / 4 + 3;
      held_mask = MASK_W'($urandom_range(0, 511));

      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: any mask, any time, any presence
          send_poll(MASK_W'($urandom), $urandom, 1'($urandom), 1'b0, CODE_NONE);
        end else begin
          // mostly hold the buttons while time moves forward
          if (roll < 11) clock_ms = clock_ms - TIME_W'($urandom_range(0, 50));
          else clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
          roll = $urandom_range(0, 99);
          if (roll < 4) held_mask = MASK_W'($urandom_range(0, 511));
          else if (roll < 14) held_mask[$urandom_range(0, MASK_W - 1)] ^= 1'b1;
          send_poll(held_mask, clock_ms, 1'($urandom_range(0, 24) != 0), 1'b0, CODE_NONE);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/brap_pkg.sv
rtl/brap_mod.sv
rtl/button_auto_repeat_priority.sv
bench/button_auto_repeat_priority_tb.sv
